### rtl/shs_pkg.sv
// Shared types, constants and round functions for the SHA-256 stream hasher.
package shs_pkg;

    localparam int WordW  = 32;
    localparam int Rounds = 64;

    // Controller to datapath commands
    typedef struct packed {
        logic take_beat;   // input beat accepted
        logic pad;         // append the 0x80 byte
        logic len;         // write the bit length into words 14 and 15
        logic load;        // copy hash words into working words
        logic round;       // one compression round
        logic add;         // fold working words into hash, clear block
        logic finish;      // digest delivered, back to initial values
    } shs_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [5:0] byte_cnt;
    } shs_stat_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PAD   = 7'b0000010,
        ST_LEN   = 7'b0000100,
        ST_LOAD  = 7'b0001000,
        ST_ROUND = 7'b0010000,
        ST_ADD   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } shs_state_t;

    typedef enum logic [1:0] {
        RET_IDLE = 2'd0,
        RET_PAD  = 2'd1,
        RET_LEN  = 2'd2,
        RET_OUT  = 2'd3
    } shs_ret_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        logic [31:0] r;
        begin
            unique case (i)
                3'd0: r = 32'h6a09e667;
                3'd1: r = 32'hbb67ae85;
                3'd2: r = 32'h3c6ef372;
                3'd3: r = 32'ha54ff53a;
                3'd4: r = 32'h510e527f;
                3'd5: r = 32'h9b05688c;
                3'd6: r = 32'h1f83d9ab;
                default: r = 32'h5be0cd19;
            endcase
            return r;
        end
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k [0:63];
        begin
            k = '{
                32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
                32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
                32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
                32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
                32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
                32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
                32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
                32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
                32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
                32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
                32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
                32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
                32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
                32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
                32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
                32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
            return k[t];
        end
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        begin
            d = {x, x} >> n;
            return d[31:0];
        end
    endfunction

    function automatic logic [31:0] small_s0(input logic [31:0] x);
        return rotr(x, 5'd7) ^ rotr(x, 5'd18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_s1(input logic [31:0] x);
        return rotr(x, 5'd17) ^ rotr(x, 5'd19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        return rotr(x, 5'd2) ^ rotr(x, 5'd13) ^ rotr(x, 5'd22);
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        return rotr(x, 5'd6) ^ rotr(x, 5'd11) ^ rotr(x, 5'd25);
    endfunction

endpackage

### rtl/sha256_byte_stream_hasher_unit.sv
// A beat that fills a block stalls the input for the compression (load, 64 rounds, add) before the next.
// Other data beats do not stall the input. The final beat is followed by the pad and length steps, one or
// two compressions, then 8 digest beats, one per cycle while m_tready is high.
// Input is not accepted while a block is being compressed by the single round unit.
// Reset (rst_n low, async): hash words to initial values, length and byte count to zero.
// Top level of the SHA-256 byte stream hasher.
module sha256_byte_stream_hasher_unit
    import shs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_present
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast    // last_word
);

    shs_cmd_t   cmd;
    shs_stat_t  stat;
    logic [5:0] rnd;
    logic [2:0] out_idx;

    shs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd),
        .rnd      (rnd),
        .out_idx  (out_idx)
    );

    shs_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_byte    (s_tdata),
        .in_present (s_tuser),
        .rnd        (rnd),
        .out_idx    (out_idx),
        .stat       (stat),
        .digest     (m_tdata)
    );

    assign m_tuser = out_idx;
    assign m_tlast = (out_idx == 3'd7);

endmodule

### rtl/shs_datapath.sv
// Datapath: block buffer and rolling schedule, working words, hash words, length.
module shs_datapath
    import shs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  shs_cmd_t    cmd,
    input  logic [7:0]  in_byte,
    input  logic        in_present,
    input  logic [5:0]  rnd,
    input  logic [2:0]  out_idx,
    output shs_stat_t   stat,
    output logic [31:0] digest
);

    logic [31:0] hash_reg [8];
    logic [31:0] hash_next [8];
    logic [31:0] work_reg [8];
    logic [31:0] work_next [8];
    logic [31:0] win_reg [16];
    logic [31:0] win_next [16];
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] len_reg, len_next;

    logic [7:0]  put_byte;
    logic        put_en;
    logic [31:0] put_word;
    logic [31:0] t1, t2, w_new;

    assign stat.byte_cnt = cnt_reg;
    assign digest        = hash_reg[out_idx];

    // byte placement, big-endian within the word
    assign put_en   = (cmd.take_beat && in_present) || cmd.pad;
    assign put_byte = cmd.pad ? PAD_BYTE : in_byte;
    always_comb
    begin
        unique case (cnt_reg[1:0])
            2'd0: put_word = {put_byte, 24'd0};
            2'd1: put_word = {8'd0, put_byte, 16'd0};
            2'd2: put_word = {16'd0, put_byte, 8'd0};
            default: put_word = {24'd0, put_byte};
        endcase
    end

    // round arithmetic
    assign t1 = work_reg[7] + big_s1(work_reg[4])
              + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
              + round_k(rnd) + win_reg[0];
    assign t2 = big_s0(work_reg[0])
              + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
                 ^ (work_reg[1] & work_reg[2]));
    assign w_new = small_s1(win_reg[14]) + win_reg[9] + small_s0(win_reg[1]) + win_reg[0];

    always_comb
    begin
        hash_next = hash_reg;
        work_next = work_reg;
        win_next  = win_reg;
        cnt_next  = cnt_reg;
        len_next  = len_reg;
        if (put_en)
        begin
            win_next[cnt_reg[5:2]] = win_reg[cnt_reg[5:2]] | put_word;
            cnt_next = cnt_reg + 6'd1;
        end
        if (cmd.take_beat && in_present)
            len_next = len_reg + 64'd8;
        if (cmd.len)
        begin
            win_next[14] = len_reg[63:32];
            win_next[15] = len_reg[31:0];
        end
        if (cmd.load)
            work_next = hash_reg;
        // window shifts so word 0 always holds this round's schedule word
        if (cmd.round)
        begin
            for (int i = 0; i < 15; i++)
                win_next[i] = win_reg[i + 1];
            win_next[15] = w_new;
            for (int i = 7; i > 0; i--)
                work_next[i] = work_reg[i - 1];
            work_next[4] = work_reg[3] + t1;
            work_next[0] = t1 + t2;
        end
        if (cmd.add)
        begin
            for (int i = 0; i < 8; i++)
                hash_next[i] = hash_reg[i] + work_reg[i];
            for (int i = 0; i < 16; i++)
                win_next[i] = '0;
            cnt_next = '0;
        end
        if (cmd.finish)
        begin
            for (int i = 0; i < 8; i++)
                hash_next[i] = init_hash(3'(i));
            len_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= init_hash(3'(i));
                work_reg[i] <= '0;
            end
            for (int i = 0; i < 16; i++)
                win_reg[i] <= '0;
            cnt_reg <= '0;
            len_reg <= '0;
        end
        else
        begin
            hash_reg <= hash_next;
            work_reg <= work_next;
            win_reg  <= win_next;
            cnt_reg  <= cnt_next;
            len_reg  <= len_next;
        end
    end

endmodule

### rtl/shs_ctrl.sv
// Controller: sequences byte intake, padding, compression rounds and digest beats.
module shs_ctrl
    import shs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic       s_tuser,
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  shs_stat_t  stat,
    output shs_cmd_t   cmd,
    output logic [5:0] rnd,
    output logic [2:0] out_idx
);

    shs_state_t state_reg, state_next;
    shs_ret_t   ret_reg, ret_next;
    logic [5:0] rnd_reg, rnd_next;
    logic [2:0] idx_reg, idx_next;
    logic       s_acc, m_acc;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;
    assign rnd      = rnd_reg;
    assign out_idx  = idx_reg;

    // command decode
    always_comb
    begin
        cmd           = '0;
        cmd.take_beat = s_acc;
        cmd.pad       = (state_reg == ST_PAD);
        cmd.len       = (state_reg == ST_LEN);
        cmd.load      = (state_reg == ST_LOAD);
        cmd.round     = (state_reg == ST_ROUND);
        cmd.add       = (state_reg == ST_ADD);
        cmd.finish    = m_acc && (idx_reg == 3'd7);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    if (s_tuser && stat.byte_cnt == 6'd63)
                    begin
                        state_next = ST_LOAD;
                        ret_next   = s_tlast ? RET_PAD : RET_IDLE;
                    end
                    else if (s_tlast)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                // no room for the length after the pad byte: extra block
                if (stat.byte_cnt >= 6'd56)
                begin
                    state_next = ST_LOAD;
                    ret_next   = RET_LEN;
                end
                else
                    state_next = ST_LEN;
            end
            ST_LEN:
            begin
                state_next = ST_LOAD;
                ret_next   = RET_OUT;
            end
            ST_LOAD:
            begin
                state_next = ST_ROUND;
                rnd_next   = '0;
            end
            ST_ROUND:
            begin
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'(Rounds - 1))
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                unique case (ret_reg)
                    RET_IDLE: state_next = ST_IDLE;
                    RET_PAD:  state_next = ST_PAD;
                    RET_LEN:  state_next = ST_LEN;
                    default:
                    begin
                        state_next = ST_OUT;
                        idx_next   = '0;
                    end
                endcase
            end
            default:
            begin
                if (m_acc)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                        state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= RET_IDLE;
            rnd_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while digest pending");
    a_round_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && rnd_reg == 6'd63) |=> (state_reg == ST_ADD))
        else $error("compression did not end after last round");
    a_digest_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_acc && idx_reg == 3'd7) |=> (s_tready && idx_reg == 3'd0))
        else $error("no return to idle after last digest beat");
    a_out_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> (idx_reg == 3'd0))
        else $error("digest does not start at word 0");
`endif

endmodule
